/* src/trz_pkg.sv */
// Shared types and constants for the triangle rasterizer with depth store.
package trz_pkg;

    // Internal widths of the fixed-point datapath.
    localparam int SW  = 22;   // screen coordinate, 8 fraction bits
    localparam int DW  = 24;   // coordinate differences
    localparam int EW  = 48;   // edge values and area
    localparam int PW  = 65;   // edge times depth or channel
    localparam int NW  = 67;   // sum of three depth products
    localparam int DNW = 66;   // divider numerator magnitude
    localparam int QW  = 17;   // divider quotient bits

    localparam logic [31:0]        RESET_COLOR = 32'hFF0000FF;
    localparam logic signed [15:0] DEPTH_ONE   = 16'sd16384;
    localparam logic [7:0]         ALPHA_OPQ   = 8'hFF;

    // Command codes of an input item.
    typedef enum logic [1:0] {
        CMD_DRAW  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic signed [15:0] first_z;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
        logic signed [15:0] second_z;
        logic signed [15:0] third_x;
        logic signed [15:0] third_y;
        logic signed [15:0] third_z;
        logic [23:0]        color_rgb;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        read_color;
        logic signed [15:0] read_depth;
        logic [14:0]        pixels_written;
        logic               was_culled;
    } t_out_item;

    // Datapath operations issued by the controller.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MAP,
        OP_BOX,
        OP_SMUL,
        OP_CULL,
        OP_FLIP,
        OP_PMUL,
        OP_DIVZ,
        OP_ZFIN,
        OP_DIVC,
        OP_CFIN,
        OP_WRITE,
        OP_STEP,
        OP_RDFIN,
        OP_CLRB_RST,
        OP_CLRB,
        OP_CLR
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [2:0] sel;
    } t_dp_cmd;

    typedef struct packed {
        logic area_zero;
        logic area_neg;
        logic box_empty;
        logic covered;
        logic depth_pass;
        logic last_pix;
        logic div_done;
        logic clr_last;
    } t_dp_stat;

    typedef enum logic [4:0] {
        S_INIT,
        S_ICLR,
        S_IDLE,
        S_CLRB,
        S_CLR,
        S_RD0,
        S_RD1,
        S_MAP,
        S_BOX,
        S_SMUL,
        S_SWAIT,
        S_CHK,
        S_CULL,
        S_PIX,
        S_ZMUL,
        S_ZACC,
        S_ZDIVS,
        S_ZDIV,
        S_ZFIN,
        S_ZCMP,
        S_CMUL,
        S_CDIVS,
        S_CDIV,
        S_CFIN,
        S_WRITE,
        S_ADV,
        S_DONE
    } t_state;

endpackage

/* src/trz_div.sv */
// Restoring divider that produces a short quotient, one bit per cycle.
module trz_div import trz_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DNW-1:0]   i_num,
    input  logic [EW-1:0]    i_den,
    output logic [QW-1:0]    o_quot,
    output logic             o_rem_nz,
    output logic             o_busy
);

    localparam int CW = $clog2(QW);

    logic            r_busy;
    logic [CW-1:0]   r_cnt;
    logic [DNW-1:0]  r_rem;
    logic [DNW-1:0]  r_dvs;
    logic [QW-1:0]   r_q;
    logic            w_ge;

    assign w_ge = (r_rem >= r_dvs);

    // Step counter and busy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(QW - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // One compare and subtract per cycle against the shifted divisor.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dvs <= DNW'(i_den) << (QW - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (r_rem - r_dvs) : r_rem;
            r_q   <= {r_q[QW-2:0], w_ge};
            r_dvs <= r_dvs >> 1;
        end
    end

    assign o_quot   = r_q;
    assign o_rem_nz = (r_rem != '0);
    assign o_busy   = r_busy;

endmodule

/* src/trz_ctrl.sv */
// Controller state machine that sequences the reset clear and clear, read, draw and no-op items.
module trz_ctrl import trz_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_cmd     i_cmd,
    input  logic     i_cfg_we,
    input  logic     i_cfg_data,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_done
);

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic       r_cull;

    // State, step counter and culling register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_step  <= '0;
            r_cull  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (i_cfg_we) begin
                r_cull <= i_cfg_data;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_INIT: n_state = S_ICLR;
            S_ICLR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_step = '0;
                    case (i_cmd)
                        CMD_DRAW:  n_state = S_MAP;
                        CMD_CLEAR: n_state = S_CLRB;
                        CMD_READ:  n_state = S_RD0;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_CLRB: n_state = S_CLR;
            S_CLR: begin
                if (i_stat.clr_last) n_state = S_DONE;
            end
            S_RD0: n_state = S_RD1;
            S_RD1: n_state = S_DONE;
            S_MAP: n_state = S_BOX;
            S_BOX: n_state = S_SMUL;
            S_SMUL: begin
                n_step = r_step + 1'b1;
                if (r_step == 3'd7) n_state = S_SWAIT;
            end
            S_SWAIT: n_state = S_CHK;
            S_CHK: begin
                if (r_cull && (i_stat.area_zero || i_stat.area_neg)) begin
                    n_state = S_CULL;
                end else if (i_stat.area_zero || i_stat.box_empty) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_PIX;
                end
            end
            S_CULL: n_state = S_DONE;
            S_PIX: begin
                n_step  = '0;
                n_state = i_stat.covered ? S_ZMUL : S_ADV;
            end
            S_ZMUL: begin
                n_step = r_step + 1'b1;
                if (r_step == 3'd2) n_state = S_ZACC;
            end
            S_ZACC:  n_state = S_ZDIVS;
            S_ZDIVS: n_state = S_ZDIV;
            S_ZDIV: begin
                if (i_stat.div_done) n_state = S_ZFIN;
            end
            S_ZFIN: n_state = S_ZCMP;
            S_ZCMP: begin
                n_step  = '0;
                n_state = i_stat.depth_pass ? S_CMUL : S_ADV;
            end
            S_CMUL:  n_state = S_CDIVS;
            S_CDIVS: n_state = S_CDIV;
            S_CDIV: begin
                if (i_stat.div_done) n_state = S_CFIN;
            end
            S_CFIN: begin
                n_step = r_step + 1'b1;
                n_state = (r_step == 3'd2) ? S_WRITE : S_CMUL;
            end
            S_WRITE: n_state = S_ADV;
            S_ADV:   n_state = i_stat.last_pix ? S_DONE : S_PIX;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd.op  = OP_NONE;
        o_cmd.sel = r_step;
        case (r_state)
            S_INIT:  o_cmd.op = OP_CLRB_RST;
            S_ICLR:  o_cmd.op = OP_CLR;
            S_IDLE:  o_cmd.op = start ? OP_LOAD : OP_NONE;
            S_CLRB:  o_cmd.op = OP_CLRB;
            S_CLR:   o_cmd.op = OP_CLR;
            S_RD1:   o_cmd.op = OP_RDFIN;
            S_MAP:   o_cmd.op = OP_MAP;
            S_BOX:   o_cmd.op = OP_BOX;
            S_SMUL:  o_cmd.op = OP_SMUL;
            S_CHK: begin
                if (!(r_cull && (i_stat.area_zero || i_stat.area_neg))) begin
                    o_cmd.op = OP_FLIP;
                end
            end
            S_CULL:  o_cmd.op = OP_CULL;
            S_ZMUL:  o_cmd.op = OP_PMUL;
            S_ZDIVS: o_cmd.op = OP_DIVZ;
            S_ZFIN:  o_cmd.op = OP_ZFIN;
            S_CMUL: begin
                o_cmd.op  = OP_PMUL;
                o_cmd.sel = r_step + 3'd3;
            end
            S_CDIVS: o_cmd.op = OP_DIVC;
            S_CFIN:  o_cmd.op = OP_CFIN;
            S_WRITE: o_cmd.op = OP_WRITE;
            S_ADV:   o_cmd.op = OP_STEP;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

/* src/trz_datapath.sv */
// Datapath: vertex mapping, edge functions, depth and color math, pixel stores.
module trz_datapath import trz_pkg::*; #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_item,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output t_out_item o_result
);

    localparam int NPIX = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW   = $clog2(NPIX);
    localparam int XW   = $clog2(FRAME_WIDTH);
    localparam int YW   = $clog2(FRAME_HEIGHT);
    localparam logic signed [13:0] FW_S = 14'(FRAME_WIDTH);
    localparam logic signed [13:0] FH_S = 14'(FRAME_HEIGHT);
    localparam logic signed [SW:0] XMAX = (SW+1)'(FRAME_WIDTH - 1);
    localparam logic signed [SW:0] YMAX = (SW+1)'(FRAME_HEIGHT - 1);

    // Pixel stores.
    logic [31:0]        r_color_mem [NPIX];
    logic signed [15:0] r_depth_mem [NPIX];
    logic [31:0]        r_rd_color;
    logic signed [15:0] r_rd_depth;

    t_in_item               r_item;
    t_out_item              r_res;
    logic                   r_is_read;
    logic                   r_rd_ok;
    logic [AW-1:0]          r_rd_addr;
    logic [AW-1:0]          r_clr_addr;
    logic [31:0]            r_clr_color;

    logic signed [SW-1:0]   r_sx [3];
    logic signed [SW-1:0]   r_sy [3];
    logic [XW-1:0]          r_ilo, r_ihi, r_i;
    logic [YW-1:0]          r_jlo, r_jhi, r_j;
    logic                   r_empty;

    logic signed [EW-1:0]   r_sprod, r_stmp, r_area;
    logic [1:0]             r_starget;
    logic                   r_sodd, r_sv;
    logic signed [EW-1:0]   r_e [3];
    logic signed [EW-1:0]   r_ecol [3];
    logic                   r_neg;
    logic [EW-1:0]          r_mag;

    logic signed [PW-1:0]   r_pprod;
    logic                   r_pv;
    logic [1:0]             r_psel;
    logic signed [NW-1:0]   r_num;
    logic signed [15:0]     r_zval;
    logic [7:0]             r_rgb [3];

    logic signed [15:0]     w_raw_x [3];
    logic signed [15:0]     w_raw_y [3];
    logic signed [15:0]     w_raw_z [3];
    logic signed [SW-1:0]   w_sx [3];
    logic signed [SW-1:0]   w_sy [3];
    logic signed [DW-1:0]   w_x [3];
    logic signed [DW-1:0]   w_y [3];
    logic signed [DW-1:0]   w_px, w_py;
    logic signed [SW-1:0]   w_xmin, w_xmax, w_ymin, w_ymax;
    logic signed [SW:0]     w_ilo, w_ihi, w_jlo, w_jhi;
    logic signed [DW-1:0]   w_ma, w_mb;
    logic signed [EW-1:0]   w_sprod;
    logic signed [EW-1:0]   w_dx [3];
    logic signed [EW-1:0]   w_dy [3];
    logic [1:0]             w_eidx;
    logic signed [16:0]     w_pmb;
    logic signed [PW-1:0]   w_pprod;
    logic                   w_aneg;
    logic [AW-1:0]          w_pix_addr;
    logic [AW-1:0]          w_ra, w_wa;
    logic                   w_we;
    logic [31:0]            w_wcolor;
    logic signed [15:0]     w_wdepth;
    logic                   w_div_start;
    logic [DNW-1:0]         w_div_num;
    logic [QW-1:0]          w_quot;
    logic                   w_rem_nz, w_div_busy;
    logic signed [QW:0]     w_zq;
    logic [7:0]             w_chan;

    assign w_raw_x[0] = r_item.first_x;
    assign w_raw_y[0] = r_item.first_y;
    assign w_raw_z[0] = r_item.first_z;
    assign w_raw_x[1] = r_item.second_x;
    assign w_raw_y[1] = r_item.second_y;
    assign w_raw_z[1] = r_item.second_z;
    assign w_raw_x[2] = r_item.third_x;
    assign w_raw_y[2] = r_item.third_y;
    assign w_raw_z[2] = r_item.third_z;

    // NDC to screen position with 8 fraction bits.
    always_comb begin
        logic signed [16:0] vx, vy;
        logic signed [30:0] mx, my;
        for (int k = 0; k < 3; k++) begin
            vx = 17'(w_raw_x[k]) + 17'sd16384;
            vy = 17'(w_raw_y[k]) + 17'sd16384;
            mx = 31'(vx) * 31'(FW_S);
            my = 31'(vy) * 31'(FH_S);
            w_sx[k] = mx[SW+6:7];
            w_sy[k] = my[SW+6:7];
            w_x[k]  = DW'(r_sx[k]);
            w_y[k]  = DW'(r_sy[k]);
        end
    end

    // Bounding box of pixel centers, clamped to the frame.
    always_comb begin
        w_xmin = r_sx[0];
        w_xmax = r_sx[0];
        w_ymin = r_sy[0];
        w_ymax = r_sy[0];
        for (int k = 1; k < 3; k++) begin
            if (r_sx[k] < w_xmin) w_xmin = r_sx[k];
            if (r_sx[k] > w_xmax) w_xmax = r_sx[k];
            if (r_sy[k] < w_ymin) w_ymin = r_sy[k];
            if (r_sy[k] > w_ymax) w_ymax = r_sy[k];
        end
        w_ilo = ((SW+1)'(w_xmin) + (SW+1)'(127)) >>> 8;
        w_ihi = ((SW+1)'(w_xmax) - (SW+1)'(128)) >>> 8;
        w_jlo = ((SW+1)'(w_ymin) + (SW+1)'(127)) >>> 8;
        w_jhi = ((SW+1)'(w_ymax) - (SW+1)'(128)) >>> 8;
        if (w_ilo < 0) w_ilo = '0;
        if (w_jlo < 0) w_jlo = '0;
        if (w_ihi > XMAX) w_ihi = XMAX;
        if (w_jhi > YMAX) w_jhi = YMAX;
    end

    // Center of the first pixel of the box.
    assign w_px = DW'({r_ilo, 8'h80});
    assign w_py = DW'({r_jlo, 8'h80});

    // Operands of the setup products: area, then each edge.
    always_comb begin
        case (i_cmd.sel)
            3'd0: begin w_ma = w_x[2] - w_x[0]; w_mb = w_y[1] - w_y[0]; end
            3'd1: begin w_ma = w_y[2] - w_y[0]; w_mb = w_x[1] - w_x[0]; end
            3'd2: begin w_ma = w_px - w_x[1];   w_mb = w_y[2] - w_y[1]; end
            3'd3: begin w_ma = w_py - w_y[1];   w_mb = w_x[2] - w_x[1]; end
            3'd4: begin w_ma = w_px - w_x[2];   w_mb = w_y[0] - w_y[2]; end
            3'd5: begin w_ma = w_py - w_y[2];   w_mb = w_x[0] - w_x[2]; end
            3'd6: begin w_ma = w_px - w_x[0];   w_mb = w_y[1] - w_y[0]; end
            3'd7: begin w_ma = w_py - w_y[0];   w_mb = w_x[1] - w_x[0]; end
            default: begin w_ma = '0; w_mb = '0; end
        endcase
        w_sprod = EW'(w_ma) * EW'(w_mb);
    end

    // Per-pixel steps of each edge along columns and rows.
    always_comb begin
        logic signed [EW-1:0] ax, ay;
        for (int k = 0; k < 3; k++) begin
            ay = EW'(w_y[(k + 2) % 3] - w_y[(k + 1) % 3]);
            ax = EW'(w_x[(k + 2) % 3] - w_x[(k + 1) % 3]);
            w_dx[k] = r_neg ? -(ay <<< 8) : (ay <<< 8);
            w_dy[k] = r_neg ? (ax <<< 8) : -(ax <<< 8);
        end
    end

    // Operands of the pixel products: edge times depth or channel.
    always_comb begin
        case (i_cmd.sel)
            3'd0: begin w_eidx = 2'd0; w_chan = 8'h00; end
            3'd1: begin w_eidx = 2'd1; w_chan = 8'h00; end
            3'd2: begin w_eidx = 2'd2; w_chan = 8'h00; end
            3'd3: begin w_eidx = 2'd0; w_chan = r_item.color_rgb[7:0]; end
            3'd4: begin w_eidx = 2'd1; w_chan = r_item.color_rgb[15:8]; end
            3'd5: begin w_eidx = 2'd2; w_chan = r_item.color_rgb[23:16]; end
            default: begin w_eidx = 2'd0; w_chan = 8'h00; end
        endcase
        w_pmb   = (i_cmd.sel < 3'd3) ? 17'(w_raw_z[w_eidx]) : 17'({1'b0, w_chan});
        w_pprod = PW'(r_e[w_eidx]) * PW'(w_pmb);
    end

    assign w_aneg = r_area[EW-1];

    // Divider feed and depth rounding toward minus infinity.
    assign w_div_start = (i_cmd.op == OP_DIVZ) || (i_cmd.op == OP_DIVC);
    assign w_div_num   = (i_cmd.op == OP_DIVZ)
                       ? (r_num[NW-1] ? DNW'(-r_num) : DNW'(r_num))
                       : DNW'(r_pprod);
    assign w_zq = r_num[NW-1] ? (-$signed({1'b0, w_quot}) - (QW+1)'(w_rem_nz))
                              : $signed({1'b0, w_quot});

    trz_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_num    (w_div_num),
        .i_den    (r_mag),
        .o_quot   (w_quot),
        .o_rem_nz (w_rem_nz),
        .o_busy   (w_div_busy)
    );

    // Store addressing and write data.
    assign w_pix_addr = AW'(r_j * FRAME_WIDTH) + AW'(r_i);
    assign w_ra       = r_is_read ? r_rd_addr : w_pix_addr;
    assign w_we       = (i_cmd.op == OP_CLR) || (i_cmd.op == OP_WRITE);
    assign w_wa       = (i_cmd.op == OP_CLR) ? r_clr_addr : w_pix_addr;
    assign w_wcolor   = (i_cmd.op == OP_CLR) ? r_clr_color
                      : {ALPHA_OPQ, r_rgb[2], r_rgb[1], r_rgb[0]};
    assign w_wdepth   = (i_cmd.op == OP_CLR) ? DEPTH_ONE : r_zval;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_color_mem[w_wa] <= w_wcolor;
            r_depth_mem[w_wa] <= w_wdepth;
        end
        r_rd_color <= r_color_mem[w_ra];
        r_rd_depth <= r_depth_mem[w_ra];
    end

    // Product valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_pv <= 1'b0;
        end else begin
            r_sv <= (i_cmd.op == OP_SMUL);
            r_pv <= (i_cmd.op == OP_PMUL) && (i_cmd.sel < 3'd3);
        end
    end

    // Datapath registers, driven by the current operation.
    always_ff @(posedge i_clk) begin
        r_sprod   <= w_sprod;
        r_starget <= i_cmd.sel[2:1];
        r_sodd    <= i_cmd.sel[0];
        r_pprod   <= w_pprod;
        r_psel    <= i_cmd.sel[1:0];

        // Setup products pair up into the area and each edge.
        if (r_sv) begin
            if (!r_sodd) begin
                r_stmp <= r_sprod;
            end else if (r_starget == 2'd0) begin
                r_area <= r_stmp - r_sprod;
            end else begin
                r_e[r_starget - 2'd1] <= r_stmp - r_sprod;
            end
        end

        // Depth products sum into the interpolation numerator.
        if (r_pv) begin
            if (r_psel == 2'd0) begin
                r_num <= NW'(r_pprod);
            end else begin
                r_num <= r_num + NW'(r_pprod);
            end
        end

        case (i_cmd.op)
            OP_LOAD: begin
                r_item    <= i_item;
                r_res     <= '0;
                r_is_read <= (i_item.cmd == CMD_READ);
                r_rd_ok   <= (i_item.first_x >= 0) && (i_item.first_x < FRAME_WIDTH)
                          && (i_item.first_y >= 0) && (i_item.first_y < FRAME_HEIGHT);
                r_rd_addr <= AW'(i_item.first_y[YW-1:0] * FRAME_WIDTH)
                           + AW'(i_item.first_x[XW-1:0]);
            end
            OP_MAP: begin
                for (int k = 0; k < 3; k++) begin
                    r_sx[k] <= w_sx[k];
                    r_sy[k] <= w_sy[k];
                end
            end
            OP_BOX: begin
                r_ilo   <= w_ilo[XW-1:0];
                r_ihi   <= w_ihi[XW-1:0];
                r_jlo   <= w_jlo[YW-1:0];
                r_jhi   <= w_jhi[YW-1:0];
                r_empty <= (w_ilo > w_ihi) || (w_jlo > w_jhi);
            end
            OP_CULL: begin
                r_res.was_culled <= 1'b1;
            end
            OP_FLIP: begin
                r_neg <= w_aneg;
                r_mag <= w_aneg ? EW'(-r_area) : EW'(r_area);
                r_i   <= r_ilo;
                r_j   <= r_jlo;
                for (int k = 0; k < 3; k++) begin
                    r_e[k]    <= w_aneg ? -r_e[k] : r_e[k];
                    r_ecol[k] <= w_aneg ? -r_e[k] : r_e[k];
                end
            end
            OP_ZFIN: begin
                r_zval <= w_zq[15:0];
            end
            OP_CFIN: begin
                r_rgb[i_cmd.sel[1:0]] <= w_quot[7:0];
            end
            OP_WRITE: begin
                if (r_res.pixels_written != 15'h7FFF) begin
                    r_res.pixels_written <= r_res.pixels_written + 15'd1;
                end
            end
            OP_STEP: begin
                // Rows inside a column, then the next column.
                if (r_j != r_jhi) begin
                    r_j <= r_j + 1'b1;
                    for (int k = 0; k < 3; k++) begin
                        r_e[k] <= r_e[k] + w_dy[k];
                    end
                end else begin
                    r_i <= r_i + 1'b1;
                    r_j <= r_jlo;
                    for (int k = 0; k < 3; k++) begin
                        r_ecol[k] <= r_ecol[k] + w_dx[k];
                        r_e[k]    <= r_ecol[k] + w_dx[k];
                    end
                end
            end
            OP_RDFIN: begin
                if (r_rd_ok) begin
                    r_res.read_color <= r_rd_color;
                    r_res.read_depth <= r_rd_depth;
                end
            end
            OP_CLRB_RST: begin
                r_clr_addr  <= '0;
                r_clr_color <= RESET_COLOR;
                r_is_read   <= 1'b0;
            end
            OP_CLRB: begin
                r_clr_addr  <= '0;
                r_clr_color <= {ALPHA_OPQ, r_item.color_rgb};
            end
            OP_CLR: begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Status to the controller.
    always_comb begin
        o_stat.area_zero  = (r_area == '0);
        o_stat.area_neg   = w_aneg;
        o_stat.box_empty  = r_empty;
        o_stat.covered    = !r_e[0][EW-1] && !r_e[1][EW-1] && !r_e[2][EW-1];
        o_stat.depth_pass = (r_zval < r_rd_depth);
        o_stat.last_pix   = (r_i == r_ihi) && (r_j == r_jhi);
        o_stat.div_done   = !w_div_busy;
        o_stat.clr_last   = (r_clr_addr == AW'(NPIX - 1));
    end

    assign o_result = r_res;

endmodule

/* src/triangle_raster_zbuffer_top.sv */
// Top level of the triangle rasterizer with color and depth stores.
// Reset runs a clearing pass with busy high. Clear writes one store entry a cycle.
// Draw runs setup, then visits each box pixel: an uncovered pixel is skipped, a pixel
// that fails the depth test skips the color work, and a written pixel takes three
// color divides on the shared divider before the store write.
// One item at a time; each result shows for one cycle on o_done and cannot be stalled.
module triangle_raster_zbuffer_top import trz_pkg::*; #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_done,
    output t_out_item o_result,
    input  logic      i_cfg_we,
    input  logic      i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    trz_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_cmd      (i_item.cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (busy),
        .o_done     (o_done)
    );

    trz_datapath #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_result (o_result)
    );

endmodule
